>>> rtl/itr_pkg.sv
// Shared types, character codes and the digit glyph function for the radix text converter.
package itr_pkg;

    localparam int RADIX_W = 5;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam int DIGIT_W = 4;
    localparam int STEP_BITS = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic                negative;
        logic [RADIX_W-1:0]  radix;
    } itr_hdr_t;

    typedef struct packed {
        logic                minus;
        logic [DIGIT_W-1:0]  digit;
    } itr_sym_t;

    function automatic logic [7:0] itr_glyph(input itr_sym_t sym);
        logic [7:0] code;
        if (sym.minus) begin
            code = CHAR_MINUS;
        end else if (sym.digit < DIGIT_TEN) begin
            code = CHAR_ZERO + {4'd0, sym.digit};
        end else begin
            code = CHAR_A + {4'd0, sym.digit - DIGIT_TEN};
        end
        return code;
    endfunction

endpackage

>>> rtl/itr_front.sv
// Front end: holds the radix register and turns each input item into sign, magnitude and base.
module itr_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [itr_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic signed [31:0]         s_value,
    output itr_pkg::itr_hdr_t          job_hdr,
    output logic [VALUE_BITS-1:0]      job_mag
);
    import itr_pkg::*;

    logic [RADIX_W-1:0]       radix_reg;
    logic [VALUE_BITS+31:0]   value_ext;
    logic [VALUE_BITS-1:0]    value_word;
    logic                     negative;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    assign value_ext  = {{VALUE_BITS{1'b0}}, s_value};
    assign value_word = value_ext[VALUE_BITS-1:0];
    assign negative   = value_word[VALUE_BITS-1];

    always_comb begin
        job_hdr.negative = negative;
        if (radix_reg < RADIX_MIN) begin
            job_hdr.radix = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            job_hdr.radix = RADIX_MAX;
        end else begin
            job_hdr.radix = radix_reg;
        end
        job_mag = negative ? (~value_word + 1'b1) : value_word;
    end

endmodule

>>> rtl/itr_fifo.sv
// Two-entry register queue that decouples the front end from the conversion back end.
module itr_fifo #(
    parameter int WIDTH = 38
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import itr_pkg::*;

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/itr_back.sv
// Back end: extracts digits by iterative division, buffers them and sends characters in order.
module itr_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  itr_pkg::itr_hdr_t      pop_hdr,
    input  logic [VALUE_BITS-1:0]  pop_mag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_character,
    output logic                   m_last
);
    import itr_pkg::*;

    localparam int CYCLES    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD       = CYCLES * STEP_BITS;
    localparam int STEP_W    = (CYCLES > 1) ? $clog2(CYCLES) : 1;
    localparam int MAX_CHARS = VALUE_BITS + 1;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SIGN = 4'b0100,
        B_EMIT = 4'b1000
    } back_state_t;

    back_state_t          state_reg;
    logic [PAD-1:0]       work_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     emit_left_reg;
    logic                 neg_reg;
    logic [RADIX_W-1:0]   radix_reg;

    itr_sym_t             mem [MAX_CHARS];
    itr_sym_t             rd_sym_reg;
    logic                 rd_valid_reg;
    logic                 rd_last_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    logic [DIGIT_W-1:0]   div_rem;
    logic [DIGIT_W:0]     div_trial;
    logic [STEP_BITS-1:0] div_q;
    logic [PAD+STEP_BITS-1:0] work_cat;
    logic [PAD-1:0]       div_work;
    logic [PAD+VALUE_BITS-1:0] mag_ext;
    logic                 last_step;
    logic                 wr_en;
    itr_sym_t             wr_sym;
    logic [CNT_W-1:0]     rd_addr_full;
    logic                 rd_move;
    logic                 rd_free;
    logic                 rd_issue;

    always_comb begin
        div_rem   = rem_reg;
        div_trial = '0;
        div_q     = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            div_trial = {div_rem, work_reg[PAD-STEP_BITS+i]};
            if (div_trial >= radix_reg) begin
                div_rem  = DIGIT_W'(div_trial - radix_reg);
                div_q[i] = 1'b1;
            end else begin
                div_rem  = div_trial[DIGIT_W-1:0];
                div_q[i] = 1'b0;
            end
        end
    end

    assign work_cat  = {work_reg, div_q};
    assign div_work  = work_cat[PAD-1:0];
    assign mag_ext   = {{PAD{1'b0}}, pop_mag};
    assign last_step = (step_reg == STEP_W'(CYCLES - 1));
    assign pop_ready = (state_reg == B_IDLE);

    assign wr_en        = ((state_reg == B_DIV) && last_step) || (state_reg == B_SIGN);
    assign wr_sym.minus = (state_reg == B_SIGN);
    assign wr_sym.digit = (state_reg == B_SIGN) ? '0 : div_rem;

    assign rd_move      = rd_valid_reg && (!out_valid_reg || m_ready);
    assign rd_free      = !rd_valid_reg || rd_move;
    assign rd_issue     = (state_reg == B_EMIT) && (emit_left_reg != '0) && rd_free;
    assign rd_addr_full = emit_left_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            emit_left_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        step_reg  <= '0;
                        count_reg <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (last_step) begin
                        step_reg  <= '0;
                        count_reg <= count_reg + 1'b1;
                        if (div_work == '0) begin
                            if (neg_reg) begin
                                state_reg <= B_SIGN;
                            end else begin
                                emit_left_reg <= count_reg + 1'b1;
                                state_reg     <= B_EMIT;
                            end
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                B_SIGN: begin
                    count_reg     <= count_reg + 1'b1;
                    emit_left_reg <= count_reg + 1'b1;
                    state_reg     <= B_EMIT;
                end
                B_EMIT: begin
                    if (rd_issue) begin
                        emit_left_reg <= emit_left_reg - 1'b1;
                    end
                    if (emit_left_reg == '0) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase

            if (rd_issue) begin
                rd_valid_reg <= 1'b1;
            end else if (rd_move) begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == B_IDLE) && pop_valid) begin
            work_reg  <= mag_ext[PAD-1:0];
            rem_reg   <= '0;
            neg_reg   <= pop_hdr.negative;
            radix_reg <= pop_hdr.radix;
        end else if (state_reg == B_DIV) begin
            work_reg <= div_work;
            rem_reg  <= last_step ? '0 : div_rem;
        end
        if (rd_issue) begin
            rd_last_reg <= (emit_left_reg == CNT_W'(1));
        end
        if (rd_move) begin
            out_char_reg <= itr_glyph(rd_sym_reg);
            out_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= wr_sym;
        end
        if (rd_issue) begin
            rd_sym_reg <= mem[rd_addr_full[IDX_W-1:0]];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;

endmodule

>>> rtl/integer_to_radix_text.sv
// Top level of the signed integer to radix text converter.
// Each item on the s_ channel is one signed integer whose low VALUE_BITS bits are
// converted to ASCII text in the base held by the radix register (2 to 16, values
// outside that range saturate). The m_ channel returns the text of each item one character at a time,
// most significant first, with a leading '-' for negatives and m_last on the final
// character. The radix is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this. The front end queues
// up to two items; the back end divides by the base eight dividend bits per cycle,
// and stores each digit in a small digit buffer. Characters then leave from that
// buffer at one per cycle while the receiver is ready, through a registered read
// and an output register. The back end takes its next item only once every
// character of the last one has been read from that buffer.
// While the receiver stalls, the output register holds its character and the
// front end keeps taking items until the queue is full.
// Reset sets the radix to 10, empties the queue and drops any pending characters.
module integer_to_radix_text #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [itr_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_character,
    output logic                        m_last
);
    import itr_pkg::*;

    localparam int JOB_W = $bits(itr_hdr_t) + VALUE_BITS;

    itr_hdr_t              front_hdr;
    logic [VALUE_BITS-1:0] front_mag;
    logic [JOB_W-1:0]      push_data;
    logic [JOB_W-1:0]      pop_data;
    logic                  pop_valid;
    logic                  pop_ready;
    itr_hdr_t              pop_hdr;
    logic [VALUE_BITS-1:0] pop_mag;

    itr_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_value    (s_value),
        .job_hdr    (front_hdr),
        .job_mag    (front_mag)
    );

    assign push_data = {front_hdr, front_mag};

    itr_fifo #(
        .WIDTH(JOB_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_valid),
        .push_ready(s_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    assign pop_hdr = pop_data[JOB_W-1:VALUE_BITS];
    assign pop_mag = pop_data[VALUE_BITS-1:0];

    itr_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_hdr    (pop_hdr),
        .pop_mag    (pop_mag),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_character(m_character),
        .m_last     (m_last)
    );

    a_legal_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == CHAR_MINUS)
                 || ((m_character >= CHAR_ZERO) && (m_character <= CHAR_NINE))
                 || ((m_character >= CHAR_A) && (m_character <= CHAR_F)))
        else $error("Output character is not a sign or a digit.");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_character == CHAR_MINUS)) |-> !m_last)
        else $error("A minus sign was marked as the last character.");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output valid was not cleared by reset.");

endmodule

>>> tb/integer_to_radix_text_tb.sv
// Self-checking testbench for the signed integer to radix text converter.
module integer_to_radix_text_tb;

    import itr_pkg::*;

    localparam int MAX_CHARS = 33;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [RADIX_W-1:0]       cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [31:0]       s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [7:0]               m_character;
    logic                     m_last;

    logic [31:0]              pending_values[$];
    text_char_t               expected_text[$];
    logic [RADIX_W-1:0]       radix_setting = RADIX_RESET;
    logic                     in_fire = 1'b0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       hold_left = 0;
    int                       failures = 0;
    int                       cycle_count = 0;

    integer_to_radix_text #(
        .VALUE_BITS(32)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_character(m_character),
        .m_last(m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void append_expected_text(input logic [31:0] value,
                                                 input logic [RADIX_W-1:0] code);
        logic [7:0]  glyphs [0:MAX_CHARS-1];
        logic [31:0] magnitude;
        logic [31:0] base;
        logic [31:0] digit;
        logic        negative;
        int          count;
        text_char_t  entry;
        if (code < RADIX_MIN) begin
            base = 32'(RADIX_MIN);
        end else if (code > RADIX_MAX) begin
            base = 32'(RADIX_MAX);
        end else begin
            base = 32'(code);
        end
        negative = value[31];
        magnitude = negative ? -value : value;
        count = 0;
        do begin
            digit = magnitude % base;
            glyphs[count] = (digit < 10) ? CHAR_ZERO + digit[7:0]
                                         : CHAR_A + digit[7:0] - 8'd10;
            count++;
            magnitude = magnitude / base;
        end while (magnitude != 0 && count < MAX_CHARS);
        if (negative && count < MAX_CHARS) begin
            glyphs[count] = CHAR_MINUS;
            count++;
        end
        for (int k = count - 1; k >= 0; k--) begin
            entry.character = glyphs[k];
            entry.last = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(0, 40);
            1: v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        if ($urandom_range(1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_values.size() != 0 || expected_text.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_radix(input logic [RADIX_W-1:0] code);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        radix_setting = code;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: offers the oldest pending item and holds it until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_value <= pending_values[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts text for each accepted item and checks each character.
    always @(posedge aclk) begin : monitor
        text_char_t want;
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            append_expected_text(s_value, radix_setting);
            void'(pending_values.pop_front());
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $error("m_character: expected none, got %h", m_character);
                failures++;
            end else begin
                want = expected_text.pop_front();
                if (m_character !== want.character) begin
                    $error("m_character: expected %h, got %h", want.character, m_character);
                    failures++;
                end
                if (m_last !== want.last) begin
                    $error("m_last: expected %b, got %b", want.last, m_last);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 64;

        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);

        load_radix(RADIX_MAX);
        pending_values.push_back(32'hABCD_EF09);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd255);

        load_radix(RADIX_MIN);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd0);

        load_radix(5'd0);
        pending_values.push_back(32'd5);
        pending_values.push_back(-32'd6);

        load_radix(5'd1);
        pending_values.push_back(32'd3);

        load_radix(5'd17);
        pending_values.push_back(32'd255);
        pending_values.push_back(-32'd4096);

        load_radix(5'd31);
        pending_values.push_back(32'hFEDC_BA98);

        for (p = 0; p < 12; p++) begin
            if (p % 4 == 3) begin
                load_radix(RADIX_W'($urandom_range(31)));
            end else begin
                load_radix(RADIX_W'($urandom_range(2, 16)));
            end
            if (p == 4) begin
                send_idle_pct = 64;
                recv_idle_pct = 35;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 9) begin
                hold_left = 300;
            end
            for (n = 0; n < 9; n++) begin
                pending_values.push_back(random_value());
            end
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
